FILE: hw/rtl/lmrs_pkg.sv
package lmrs_pkg;

    // fixed field widths of the stream items
    localparam int ROW_W    = 6;
    localparam int IDX_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int LVL_W    = 3;
    localparam int BITS_W   = 6;
    localparam int COL_W    = 5;
    localparam int EN_W     = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // column counter carried in the command, wide enough for 8 column bytes plus the end token
    localparam int CNT_W = 7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SCAN  = 1'b1;

    typedef struct packed {
        logic             wr;
        logic             start;
        logic             issue;
        logic             last;
        logic [CNT_W-1:0] column;
    } t_dp_cmd;

    typedef struct packed {
        logic a_ready;
    } t_dp_sts;

endpackage

FILE: hw/rtl/led_matrix_row_scanner.sv
// Byte write: one transaction per cycle while no scan is busy, no result, stored at
// the accepting edge. Scan of a level below LEVELS: COLUMN_BYTES*8 shift words, then
// the row-enable word, one per cycle while the output is taken; the first shift word
// is registered in stage A, then in the output register. A scan blocks the input through
// one issue per column and one for the enable token, paced by the column counter.
// Reset (i_rst_n, synchronous, active low) clears controller, pipeline and frame valids.
module led_matrix_row_scanner #(
    parameter int LEVELS       = 8,
    parameter int DATA_LINES   = 6,
    parameter int COLUMN_BYTES = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] frame_row, [7:6] byte_index, [15:8] byte_value, [18:16] scan_level, [23:19] zero
    input  logic [lmrs_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // [0] action
    input  logic                             s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] data_bits, [10:6] column, [18:11] row_enable, [23:19] zero
    output logic [lmrs_pkg::M_DATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tlast
);
    import lmrs_pkg::*;

    // input transaction fields
    logic [ROW_W-1:0]  in_row;
    logic [IDX_W-1:0]  in_idx;
    logic [BYTE_W-1:0] in_value;
    logic [LVL_W-1:0]  in_level;

    assign in_row   = s_axis_tdata[5:0];
    assign in_idx   = s_axis_tdata[7:6];
    assign in_value = s_axis_tdata[15:8];
    assign in_level = s_axis_tdata[18:16];

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    logic [BITS_W-1:0] out_bits;
    logic [COL_W-1:0]  out_col;
    logic [EN_W-1:0]   out_en;

    // controller: accepts transactions, walks the columns of a scan
    lmrs_ctrl #(
        .LEVELS       (LEVELS),
        .COLUMN_BYTES (COLUMN_BYTES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_level  (in_level),
        .o_cmd    (dp_cmd),
        .i_sts    (dp_sts)
    );

    // datapath: one frame memory per data line, read pipeline, output register
    lmrs_datapath #(
        .LEVELS       (LEVELS),
        .DATA_LINES   (DATA_LINES),
        .COLUMN_BYTES (COLUMN_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_frame_row  (in_row),
        .i_byte_index (in_idx),
        .i_byte_value (in_value),
        .i_scan_level (in_level),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data_bits  (out_bits),
        .o_column     (out_col),
        .o_row_enable (out_en),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, out_en, out_col, out_bits};

endmodule

FILE: hw/rtl/lmrs_ctrl.sv
module lmrs_ctrl #(
    parameter int LEVELS       = 8,
    parameter int COLUMN_BYTES = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [lmrs_pkg::LVL_W-1:0]    i_level,
    output lmrs_pkg::t_dp_cmd             o_cmd,
    input  lmrs_pkg::t_dp_sts             i_sts
);
    import lmrs_pkg::*;

    localparam int COLUMNS = COLUMN_BYTES * 8;
    localparam int CW      = $clog2(COLUMNS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic          accept;
    logic          lvl_ok;
    logic          is_last;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign lvl_ok  = 32'(i_level) < LEVELS;
    assign is_last = (r_col == CW'(COLUMNS));

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else if (lvl_ok) begin
                        o_cmd.start = 1'b1;
                        n_col       = '0;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.a_ready) begin
                    o_cmd.issue  = 1'b1;
                    o_cmd.last   = is_last;
                    o_cmd.column = CNT_W'(r_col);
                    n_col        = r_col + 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
        end
    end

endmodule

FILE: hw/rtl/lmrs_datapath.sv
module lmrs_datapath #(
    parameter int LEVELS       = 8,
    parameter int DATA_LINES   = 6,
    parameter int COLUMN_BYTES = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lmrs_pkg::t_dp_cmd             i_cmd,
    output lmrs_pkg::t_dp_sts             o_sts,
    input  logic [lmrs_pkg::ROW_W-1:0]    i_frame_row,
    input  logic [lmrs_pkg::IDX_W-1:0]    i_byte_index,
    input  logic [lmrs_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [lmrs_pkg::LVL_W-1:0]    i_scan_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lmrs_pkg::BITS_W-1:0]   o_data_bits,
    output logic [lmrs_pkg::COL_W-1:0]    o_column,
    output logic [lmrs_pkg::EN_W-1:0]     o_row_enable,
    output logic                          o_last
);
    import lmrs_pkg::*;

    localparam int ROWS       = LEVELS * DATA_LINES;
    localparam int LANE_DEPTH = LEVELS * COLUMN_BYTES;
    localparam int AW         = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int LW         = (DATA_LINES > 1) ? $clog2(DATA_LINES) : 1;
    localparam int LVW        = $clog2(LEVELS);
    localparam int DW         = (DATA_LINES > BITS_W) ? DATA_LINES : BITS_W;
    localparam int EW         = (LEVELS > EN_W) ? LEVELS : EN_W;

    // write decode: frame row -> data line (lane) and level within the lane
    logic [LW-1:0]  w_lane;
    logic [LVW-1:0] w_lvl;
    logic [AW-1:0]  w_addr;
    logic           w_ok;

    always_comb begin
        w_lane = '0;
        for (int k = 1; k < DATA_LINES; k++) begin
            if (32'(i_frame_row) >= k * LEVELS) begin
                w_lane = LW'(k);
            end
        end
    end

    assign w_lvl  = LVW'(32'(i_frame_row) - 32'(w_lane) * LEVELS);
    assign w_addr = AW'(32'(w_lvl) * COLUMN_BYTES + 32'(i_byte_index));
    assign w_ok   = i_cmd.wr && (32'(i_frame_row) < ROWS) && (32'(i_byte_index) < COLUMN_BYTES);

    // read side
    logic [LVL_W-1:0] r_level;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;

    assign rd_en   = i_cmd.issue && !i_cmd.last;
    assign rd_addr = AW'(32'(r_level) * COLUMN_BYTES + 32'(i_cmd.column >> 3));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_level <= i_scan_level;
        end
    end

    logic [BYTE_W-1:0]     r_rd [DATA_LINES];
    logic [DATA_LINES-1:0] r_rv;

    for (genvar k = 0; k < DATA_LINES; k++) begin : g_lane
        logic [BYTE_W-1:0]     r_mem [LANE_DEPTH];
        logic [LANE_DEPTH-1:0] r_vld;

        always_ff @(posedge i_clk) begin
            if (w_ok && (w_lane == LW'(k))) begin
                r_mem[w_addr] <= i_byte_value;
            end
            if (rd_en) begin
                r_rd[k] <= r_mem[rd_addr];
                r_rv[k] <= r_vld[rd_addr];
            end
        end

        // unwritten entries read as dark
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= '0;
            end else if (w_ok && (w_lane == LW'(k))) begin
                r_vld[w_addr] <= 1'b1;
            end
        end
    end

    // stage A: read data plus token
    logic             r_a_v;
    logic             r_a_last;
    logic [CNT_W-1:0] r_a_col;
    logic [LVL_W-1:0] r_a_lvl;
    logic             b_free;
    logic             a_ready;

    assign b_free        = !o_valid || i_ready;
    assign a_ready       = !r_a_v || b_free;
    assign o_sts.a_ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_ready) begin
            r_a_v <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_cmd.issue) begin
            r_a_last <= i_cmd.last;
            r_a_col  <= i_cmd.column;
            r_a_lvl  <= r_level;
        end
    end

    // pixel select: msb of the byte is the leftmost column
    logic [DATA_LINES-1:0] a_word;
    logic [2:0]            bit_sel;
    logic [BITS_W-1:0]     b_bits;
    logic [COL_W-1:0]      b_col;
    logic [EN_W-1:0]       b_en;

    assign bit_sel = ~r_a_col[2:0];

    always_comb begin
        for (int k = 0; k < DATA_LINES; k++) begin
            a_word[k] = r_rv[k] & r_rd[k][bit_sel];
        end
    end

    assign b_bits = r_a_last ? '0 : BITS_W'(DW'(a_word));
    assign b_col  = r_a_last ? '0 : COL_W'(r_a_col);
    assign b_en   = r_a_last ? EN_W'(EW'(1) << (LEVELS - 1 - int'(r_a_lvl))) : '0;

    // stage B: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (b_free) begin
            o_valid <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && r_a_v) begin
            o_data_bits  <= b_bits;
            o_column     <= b_col;
            o_row_enable <= b_en;
            o_last       <= r_a_last;
        end
    end

endmodule

FILE: test/tb.sv
module tb;
    import lmrs_pkg::*;

    // block geometry, default build
    localparam int LEVELS       = 8;
    localparam int DATA_LINES   = 6;
    localparam int COLUMN_BYTES = 3;
    localparam int ROWS         = LEVELS * DATA_LINES;
    localparam int COLUMNS      = COLUMN_BYTES * 8;
    localparam int STORE_DEPTH  = ROWS * COLUMN_BYTES;

    localparam int RANDOM_ITEMS = 120;
    // scan pipeline is two deep plus the row-enable word, so this is plenty
    localparam int TAIL_CYCLES  = 60;
    // 139 items; generous margin even for the slow receiver pattern
    localparam int RUN_LIMIT    = 2_000_000;

    // one pending input transaction
    typedef struct {
        logic              act;
        logic [ROW_W-1:0]  row;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] val;
        logic [LVL_W-1:0]  lvl;
        bit                drain;   // sender holds off until all shift words are out
    } t_cmd;

    // one expected output transaction: shift word or row-enable word
    typedef struct {
        logic [BITS_W-1:0] bits;
        logic [COL_W-1:0]  col;
        logic [EN_W-1:0]   en;
        logic              last;
    } t_shift_word;

    // receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SLOW
    } t_rx_mode;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 m_axis_tlast;

    led_matrix_row_scanner #(
        .LEVELS       (LEVELS),
        .DATA_LINES   (DATA_LINES),
        .COLUMN_BYTES (COLUMN_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow of the frame store, one byte per entry, row-major
    logic [BYTE_W-1:0] frame_mem [0:STORE_DEPTH-1];
    t_cmd              cmd_q[$];
    t_shift_word       shift_word_q[$];
    int                err_cnt = 0;
    logic              in_taken = 1'b0;  // input transaction at the last rising edge

    // sender burst shaping
    int burst_left = 4;
    int gap_left   = 0;

    // receiver pattern state
    t_rx_mode rx_mode  = RX_FREE;
    int       rx_left  = 0;
    int       rx_phase = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: byte writes update the shadow frame; a scan of level L
    // yields one word per column (bit k = pixel of row L+LEVELS*k, msb of
    // byte 0 is column 0) and then the row-enable word, bit LEVELS-1-L.
    // ------------------------------------------------------------------
    function automatic void predict_item(t_cmd c);
        t_shift_word w;
        int          r;
        if (c.act == ACT_WRITE) begin
            // out-of-range row or byte index: ignored
            if (c.row < ROWS && c.idx < COLUMN_BYTES)
                frame_mem[c.row * COLUMN_BYTES + c.idx] = c.val;
        end else if (c.lvl < LEVELS) begin
            for (int col = 0; col < COLUMNS; col++) begin
                w.bits = '0;
                for (int k = 0; k < DATA_LINES; k++) begin
                    r = c.lvl + LEVELS * k;
                    w.bits[k] = frame_mem[r * COLUMN_BYTES + col / 8][7 - col % 8];
                end
                w.col  = col[COL_W-1:0];
                w.en   = '0;
                w.last = 1'b0;
                shift_word_q.push_back(w);
            end
            // row-enable word: data and column zero
            w.bits = '0;
            w.col  = '0;
            w.en   = EN_W'(1) << (LEVELS - 1 - c.lvl);
            w.last = 1'b1;
            shift_word_q.push_back(w);
        end
    endfunction

    // four-state compare so an unknown output never passes
    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
        end
    endfunction

    task automatic push_write(int row, int idx, int val, bit drain);
        t_cmd c;
        c.act   = ACT_WRITE;
        c.row   = row[ROW_W-1:0];
        c.idx   = idx[IDX_W-1:0];
        c.val   = val[BYTE_W-1:0];
        c.lvl   = LVL_W'($urandom_range(0, (1 << LVL_W) - 1));  // don't care on a write
        c.drain = drain;
        cmd_q.push_back(c);
    endtask

    task automatic push_scan(int lvl, bit drain);
        t_cmd c;
        c.act   = ACT_SCAN;
        // write fields are don't care on a scan, keep them noisy
        c.row   = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
        c.idx   = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        c.val   = BYTE_W'($urandom_range(0, (1 << BYTE_W) - 1));
        c.lvl   = lvl[LVL_W-1:0];
        c.drain = drain;
        cmd_q.push_back(c);
    endtask

    // ------------------------------------------------------------------
    // Driver: changes on the falling edge. A new transaction is presented
    // only after the previous one was taken; bursts and gaps come from
    // burst_left/gap_left. tvalid/tdata/tuser get one assignment per edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic                nv;
        logic [S_DATA_W-1:0] nd;
        logic                nu;
        t_cmd                c;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        nu = s_axis_tuser;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_q.size() > 0 &&
                         !(cmd_q[0].drain && shift_word_q.size() > 0)) begin
                c  = cmd_q.pop_front();
                nv = 1'b1;
                nd = {{(S_DATA_W-19){1'b0}}, c.lvl, c.val, c.idx, c.row};
                nu = c.act;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    // a quarter of bursts run straight into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
        s_axis_tuser  <= nu;
    end

    // Receiver backpressure: the pattern and its duration are redrawn when rx_left runs out.
    always @(negedge i_clk) begin
        logic rdy;
        if (rx_left == 0) begin
            rx_mode  = t_rx_mode'($urandom_range(0, 3));
            rx_left  = $urandom_range(10, 80);
            rx_phase = 0;
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_FREE:     rdy = 1'b1;
            RX_RANDOM:   rdy = 1'($urandom_range(0, 1));
            RX_PERIODIC: rdy = (rx_phase % 6) < 4;
            default:     rdy = ($urandom_range(0, 3) == 0);
        endcase
        m_axis_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // Monitor: rising edge. Output transactions are checked against the
    // oldest expected word; input transactions feed the predictor.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_shift_word exp_w;
        t_cmd        c;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (shift_word_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none actual data %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    exp_w = shift_word_q.pop_front();
                    check_field("data_bits",  32'(exp_w.bits), 32'(m_axis_tdata[5:0]));
                    check_field("column",     32'(exp_w.col),  32'(m_axis_tdata[10:6]));
                    check_field("row_enable", 32'(exp_w.en),   32'(m_axis_tdata[18:11]));
                    check_field("last",       32'(exp_w.last), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                c.act   = s_axis_tuser;
                c.row   = s_axis_tdata[5:0];
                c.idx   = s_axis_tdata[7:6];
                c.val   = s_axis_tdata[15:8];
                c.lvl   = s_axis_tdata[18:16];
                c.drain = 1'b0;
                predict_item(c);
            end
        end
    end

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int sel;
        for (int i = 0; i < STORE_DEPTH; i++)
            frame_mem[i] = '0;

        // directed: dark frame, extremes, ignored writes, edge levels
        push_scan(0, 1'b0);
        push_write(0, 0, 8'hFF, 1'b0);
        push_write(0, 1, 8'h80, 1'b0);
        push_write(0, 2, 8'h01, 1'b0);
        push_write(47, 2, 8'hFF, 1'b0);
        push_write(47, 0, 8'h01, 1'b0);
        push_write(40, 1, 8'hA5, 1'b0);
        push_write(8, 0, 8'h3C, 1'b0);
        push_write(48, 0, 8'hFF, 1'b0);   // row past the frame
        push_write(63, 2, 8'hFF, 1'b0);   // top row code, also past the frame
        push_write(5, 3, 8'hFF, 1'b0);    // byte index past the row
        push_scan(0, 1'b0);
        push_scan(7, 1'b0);
        push_write(0, 0, 8'h00, 1'b0);
        push_write(32, 1, 8'h5A, 1'b0);
        push_write(27, 2, 8'hC3, 1'b0);
        push_scan(0, 1'b0);
        push_scan(3, 1'b0);
        push_scan(7, 1'b0);

        // random: mostly in-range writes and scans, some stray writes;
        // up to twice the sender waits for the output to drain completely
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                push_scan($urandom_range(0, LEVELS - 1), i == 0 || i == RANDOM_ITEMS / 2);
            else if (sel < 90)
                push_write($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMN_BYTES - 1),
                           $urandom_range(0, 255), i == 0 || i == RANDOM_ITEMS / 2);
            else if (sel < 95)
                push_write($urandom_range(ROWS, 63), $urandom_range(0, 3),
                           $urandom_range(0, 255), 1'b0);
            else
                push_write($urandom_range(0, 63), 3, $urandom_range(0, 255), 1'b0);
        end

        // synchronous reset, released on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (shift_word_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && shift_word_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: led_matrix_row_scanner.f
hw/rtl/lmrs_pkg.sv
hw/rtl/lmrs_ctrl.sv
hw/rtl/lmrs_datapath.sv
hw/rtl/led_matrix_row_scanner.sv
test/tb.sv
